[hw/rtl/bbx_pkg.sv]
// Package for the 3x3 edge-aware box blur: sizes, state and phase types,
// controller/datapath command and status structs, reciprocal table.
// No dependencies.
`default_nettype none
package bbx_pkg;

	localparam int WIDTH_MAX  = 1024;
	localparam int HEIGHT_MAX = 4096;
	localparam int COL_W      = $clog2(WIDTH_MAX);
	localparam int ROW_W      = $clog2(HEIGHT_MAX);
	localparam int CFG_COLS_W = 11;
	localparam int CFG_ROWS_W = 13;
	localparam int ACC_W      = 12;   // 9 * 255 + 4 fits
	localparam int RECIP_W    = 17;   // 2^16 / n, n = 1 needs 17 bits
	localparam int RECIP_SH   = 16;
	localparam int PROD_W     = ACC_W + RECIP_W;

	localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(640);
	localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(480);

	// register indexes (word address bit 2)
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SETUP,
		S_READ,
		S_ACC,
		S_MUL,
		S_OUT
	} state_t;

	typedef enum logic {
		PH_LOAD,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic capture;   // latch accepted input transaction
		logic decide;    // store pixel, plan results, step counters
		logic setup;     // prepare window walk for one result
		logic job_sel;   // which planned result
		logic acc;       // add one window column
		logic mul;       // scale sums by reciprocal
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] njobs;
		logic       walk_done;
	} dp_stat_t;

	// ceil(2^16 / n) for the window sizes that occur; exact for sums < 2^15
	function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1:    r = RECIP_W'(65536);
			4'd2:    r = RECIP_W'(32768);
			4'd3:    r = RECIP_W'(21846);
			4'd4:    r = RECIP_W'(16384);
			4'd6:    r = RECIP_W'(10923);
			4'd9:    r = RECIP_W'(7282);
			default: r = RECIP_W'(65536);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/box_blur_3x3_edge_aware.sv]
// Top level of the 3x3 edge-aware box blur.
// Input: in_valid/in_stall with mode, red_in, green_in, blue_in. A pixel
// transaction (mode 0) carries frame pixels in raster order; after the
// frame, W drain transactions (mode 1) emit the bottom row.
// Output: out_valid/out_stall with the blurred RGB, out_row, out_col and
// frame_last. Pixel (r,c) yields result (r-1,c-1), and at a row end also
// (r-1,W-1). Out-of-phase transactions are dropped with no result.
// Config: APB port, frame width at 0x0, height at 0x4; write only while
// idle. Zero acts as 1, oversize saturates to 1024 x 4096.
// Flow: one transaction at a time. A transaction with no result passes
// through capture, decide and setup only; otherwise each of its results,
// at most two, takes a setup, a window walk and a scaling step before it
// is offered. The window walk reads one column of all three line stores
// per read/accumulate state pair. Input stays stalled while a result
// waits; a stalled result holds.
// Reset clears counters and restores 640 x 480; line stores are not
// cleared and need no pass.
// Depends on bbx_pkg, bbx_ctrl, bbx_dp.
`default_nettype none
module box_blur_3x3_edge_aware (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      mode,
	input  wire logic [7:0]                red_in,
	input  wire logic [7:0]                green_in,
	input  wire logic [7:0]                blue_in,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [7:0]                     red_out,
	output logic [7:0]                     green_out,
	output logic [7:0]                     blue_out,
	output logic [bbx_pkg::ROW_W-1:0]      out_row,
	output logic [bbx_pkg::COL_W-1:0]      out_col,
	output logic                           frame_last
);
	import bbx_pkg::*;

	logic [CFG_COLS_W-1:0] cols_q;
	logic [CFG_ROWS_W-1:0] rows_q;
	logic [COL_W-1:0]      wm1;
	logic [ROW_W-1:0]      hm1;
	dp_cmd_t               cmd;
	dp_stat_t              stat;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_COLS: cols_q <= pwdata[CFG_COLS_W-1:0];
				REG_ROWS: rows_q <= pwdata[CFG_ROWS_W-1:0];
				default:  ;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_q) : 32'(rows_q);

	// effective frame limits, last column and last row
	always_comb begin
		if (cols_q == '0) begin
			wm1 = '0;
		end else if (cols_q > CFG_COLS_W'(WIDTH_MAX)) begin
			wm1 = COL_W'(WIDTH_MAX - 1);
		end else begin
			wm1 = COL_W'(cols_q - 1'b1);
		end
		if (rows_q == '0) begin
			hm1 = '0;
		end else if (rows_q > CFG_ROWS_W'(HEIGHT_MAX)) begin
			hm1 = ROW_W'(HEIGHT_MAX - 1);
		end else begin
			hm1 = ROW_W'(rows_q - 1'b1);
		end
	end

	bbx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	bbx_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.wm1        (wm1),
		.hm1        (hm1),
		.mode       (mode),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last)
	);

endmodule
`default_nettype wire

[hw/rtl/bbx_dp.sv]
// Datapath of the box blur: three line stores, frame counters, window
// walker, sum accumulators and reciprocal scaling. Depends on bbx_pkg.
`default_nettype none
module bbx_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bbx_pkg::dp_cmd_t           cmd,
	output bbx_pkg::dp_stat_t               stat,
	input  wire logic [bbx_pkg::COL_W-1:0]  wm1,
	input  wire logic [bbx_pkg::ROW_W-1:0]  hm1,
	input  wire logic                       mode,
	input  wire logic [7:0]                 red_in,
	input  wire logic [7:0]                 green_in,
	input  wire logic [7:0]                 blue_in,
	output logic [7:0]                      red_out,
	output logic [7:0]                      green_out,
	output logic [7:0]                      blue_out,
	output logic [bbx_pkg::ROW_W-1:0]       out_row,
	output logic [bbx_pkg::COL_W-1:0]       out_col,
	output logic                            frame_last
);
	import bbx_pkg::*;

	// line stores, row r in store r mod 3
	logic [23:0] store_a_q [WIDTH_MAX];
	logic [23:0] store_b_q [WIDTH_MAX];
	logic [23:0] store_c_q [WIDTH_MAX];
	logic [23:0] rd_a_q, rd_b_q, rd_c_q;

	logic             mode_q;
	logic [23:0]      pix_q;
	logic [COL_W-1:0] col_q, drain_q;
	logic [ROW_W-1:0] row_q;
	logic [1:0]       rsel_q;
	phase_t           phase_q;

	// planned results
	logic [1:0]       njobs_q;
	logic [ROW_W-1:0] pr_q;
	logic [1:0]       prm_q;
	logic [COL_W-1:0] pc0_q, pc1_q;

	// window walk
	logic [COL_W-1:0] walk_q, c1_q, pccur_q;
	logic [2:0]       en_q;
	logic [3:0]       half_q;
	logic [RECIP_W-1:0] recip_q;
	logic             last_q;
	logic [ACC_W-1:0] acc_r_q, acc_g_q, acc_b_q;
	logic [PROD_W-1:0] prod_r_q, prod_g_q, prod_b_q;

	logic [COL_W-1:0] c_eff, r_pc, pc, c0, c1;
	logic [ROW_W-1:0] r_eff;
	logic             up, dn;
	logic [1:0]       prm_p, prm_m, nrows, ncols;
	logic [3:0]       n;
	logic [2:0]       en;

	// saturated positions
	always_comb begin
		c_eff = (col_q > wm1) ? wm1 : col_q;
		r_eff = (row_q > hm1) ? hm1 : row_q;
		r_pc  = (drain_q > wm1) ? wm1 : drain_q;
	end

	// window bounds for the selected result
	always_comb begin
		pc    = cmd.job_sel ? pc1_q : pc0_q;
		c0    = (pc == '0) ? '0 : pc - 1'b1;
		c1    = (pc >= wm1) ? wm1 : pc + 1'b1;
		up    = (pr_q != '0);
		dn    = (pr_q < hm1);
		prm_p = (prm_q == 2'd2) ? 2'd0 : prm_q + 2'd1;
		prm_m = (prm_q == 2'd0) ? 2'd2 : prm_q - 2'd1;
		for (int i = 0; i < 3; i++) begin
			en[i] = (prm_q == 2'(i)) || (up && prm_m == 2'(i)) || (dn && prm_p == 2'(i));
		end
		nrows = 2'd1 + {1'b0, up} + {1'b0, dn};
		ncols = 2'd1 + {1'b0, (pc != '0)} + {1'b0, (pc < wm1)};
		n     = {2'b00, nrows} * {2'b00, ncols};
	end

	// store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.decide && mode_q == 1'b0 && phase_q == PH_LOAD) begin
			case (rsel_q)
				2'd0:    store_a_q[c_eff] <= pix_q;
				2'd1:    store_b_q[c_eff] <= pix_q;
				default: store_c_q[c_eff] <= pix_q;
			endcase
		end
		rd_a_q <= store_a_q[walk_q];
		rd_b_q <= store_b_q[walk_q];
		rd_c_q <= store_c_q[walk_q];
	end

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			pix_q  <= {red_in, green_in, blue_in};
		end
	end

	// frame counters and result planning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
			rsel_q  <= 2'd0;
			phase_q <= PH_LOAD;
			njobs_q <= 2'd0;
		end else if (cmd.decide) begin
			if (mode_q == 1'b0 && phase_q == PH_LOAD) begin
				njobs_q <= 2'({1'b0, (r_eff != '0 && c_eff != '0)})
					+ 2'({1'b0, (r_eff != '0 && c_eff == wm1)});
				if (c_eff == wm1) begin
					col_q <= '0;
					if (r_eff == hm1) begin
						row_q   <= r_eff;
						drain_q <= '0;
						phase_q <= PH_DRAIN;
					end else begin
						row_q  <= r_eff + 1'b1;
						rsel_q <= (rsel_q == 2'd2) ? 2'd0 : rsel_q + 2'd1;
					end
				end else begin
					col_q <= c_eff + 1'b1;
					row_q <= r_eff;
				end
			end else if (mode_q == 1'b1 && phase_q == PH_DRAIN) begin
				njobs_q <= 2'd1;
				if (r_pc == wm1) begin
					phase_q <= PH_LOAD;
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= '0;
					rsel_q  <= 2'd0;
				end else begin
					drain_q <= r_pc + 1'b1;
				end
			end else begin
				njobs_q <= 2'd0;
			end
		end
	end

	// result targets (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			if (phase_q == PH_LOAD) begin
				pr_q  <= r_eff - 1'b1;
				prm_q <= (rsel_q == 2'd0) ? 2'd2 : rsel_q - 2'd1;
				pc0_q <= (c_eff != '0) ? c_eff - 1'b1 : wm1;
				pc1_q <= wm1;
			end else begin
				pr_q  <= r_eff;
				prm_q <= rsel_q;
				pc0_q <= r_pc;
				pc1_q <= wm1;
			end
		end
	end

	// window walk, accumulate, scale
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			walk_q  <= c0;
			c1_q    <= c1;
			pccur_q <= pc;
			en_q    <= en;
			half_q  <= n >> 1;
			recip_q <= recip_of(n);
			last_q  <= (pr_q == hm1) && (pc == wm1);
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end
		if (cmd.acc) begin
			acc_r_q <= acc_r_q + (en_q[0] ? ACC_W'(rd_a_q[23:16]) : '0)
				+ (en_q[1] ? ACC_W'(rd_b_q[23:16]) : '0)
				+ (en_q[2] ? ACC_W'(rd_c_q[23:16]) : '0);
			acc_g_q <= acc_g_q + (en_q[0] ? ACC_W'(rd_a_q[15:8]) : '0)
				+ (en_q[1] ? ACC_W'(rd_b_q[15:8]) : '0)
				+ (en_q[2] ? ACC_W'(rd_c_q[15:8]) : '0);
			acc_b_q <= acc_b_q + (en_q[0] ? ACC_W'(rd_a_q[7:0]) : '0)
				+ (en_q[1] ? ACC_W'(rd_b_q[7:0]) : '0)
				+ (en_q[2] ? ACC_W'(rd_c_q[7:0]) : '0);
			if (walk_q != c1_q) begin
				walk_q <= walk_q + 1'b1;
			end
		end
		if (cmd.mul) begin
			prod_r_q <= PROD_W'(acc_r_q + ACC_W'(half_q)) * PROD_W'(recip_q);
			prod_g_q <= PROD_W'(acc_g_q + ACC_W'(half_q)) * PROD_W'(recip_q);
			prod_b_q <= PROD_W'(acc_b_q + ACC_W'(half_q)) * PROD_W'(recip_q);
		end
	end

	assign stat.njobs     = njobs_q;
	assign stat.walk_done = (walk_q == c1_q);

	assign red_out    = prod_r_q[RECIP_SH+7:RECIP_SH];
	assign green_out  = prod_g_q[RECIP_SH+7:RECIP_SH];
	assign blue_out   = prod_b_q[RECIP_SH+7:RECIP_SH];
	assign out_row    = pr_q;
	assign out_col    = pccur_q;
	assign frame_last = last_q;

endmodule
`default_nettype wire

[hw/rtl/bbx_ctrl.sv]
// Controller of the box blur: sequences decide, window walk, scaling and
// output handshake for each input transaction. Depends on bbx_pkg.
`default_nettype none
module bbx_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output bbx_pkg::dp_cmd_t       cmd,
	input  wire bbx_pkg::dp_stat_t stat
);
	import bbx_pkg::*;

	state_t state_q, state_d;
	logic   job_q, job_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		job_d       = job_q;
		cmd         = '0;
		cmd.job_sel = job_q;
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_SETUP;
			end
			S_SETUP: begin
				if (stat.njobs == 2'd0) begin
					state_d = S_IDLE;
				end else begin
					cmd.setup = 1'b1;
					state_d   = S_READ;
				end
			end
			S_READ: begin
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.walk_done ? S_MUL : S_READ;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (!job_q && stat.njobs == 2'd2) begin
						job_d   = 1'b1;
						state_d = S_SETUP;
					end else begin
						job_d   = 1'b0;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
				job_d   = 1'b0;
			end
		endcase
	end

	// an accepted transaction blocks the input until it is done
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// a pending result always holds off new input
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// second result exists only when two were planned
	a_job_two: assert property (@(posedge clk) disable iff (!arst_n)
		job_q |-> stat.njobs == 2'd2)
		else $error("second result without plan");

	// after the second result the block goes idle
	a_second_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && !out_stall && job_q |=> state_q == S_IDLE)
		else $error("no return to idle after second result");

endmodule
`default_nettype wire
